@@ hdl/pott_pkg.sv @@
package pott_pkg;

  localparam int ID_W    = 32;
  localparam int TICKS_W = 16;

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_ONESHOT  = 2'd1,
    OP_PERIODIC = 2'd2,
    OP_CANCEL   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_ADDED     = 2'd0,
    KIND_FULL      = 2'd1,
    KIND_CANCELLED = 2'd2,
    KIND_FIRED     = 2'd3
  } kind_t;

  typedef struct packed {
    op_t                op;
    logic [TICKS_W-1:0] delay_ticks;
    logic [ID_W-1:0]    target_id;
  } in_item_t;

  typedef struct packed {
    kind_t           kind;
    logic [ID_W-1:0] task_id;
    logic            last;
  } out_item_t;

  // Classified command handed from the front to the back.
  typedef struct packed {
    op_t                op;
    logic [TICKS_W-1:0] load;
    logic [TICKS_W-1:0] period;
    logic [ID_W-1:0]    target;
  } cmd_t;

  // One slot as stored in the slot RAM.
  typedef struct packed {
    logic [ID_W-1:0]    ident;
    logic [TICKS_W-1:0] left;
    logic [TICKS_W-1:0] period;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND,
    ST_ADD,
    ST_SCAN,
    ST_EMIT,
    ST_CANCEL_DONE
  } state_t;

endpackage

@@ hdl/pott_ram.sv @@
module pott_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hdl/pott_sorter.sv @@
// Insertion sorter: a row of cells kept in ascending order, head at cell 0.
module pott_sorter
  import pott_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             ins,
  input  logic [ID_W-1:0]                  ins_val,
  input  logic                             pop,
  output logic [ID_W-1:0]                  head,
  output logic [$clog2(DEPTH+1)-1:0]       count
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [ID_W-1:0] val_r   [DEPTH];
  logic [ID_W-1:0] val_nxt [DEPTH];
  logic [DEPTH-1:0] vld_r, vld_nxt;
  logic [DEPTH-1:0] gt;
  logic [CW-1:0]    count_r, count_nxt;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    // empty cells compare as larger than anything: equal ids stay behind
    assign gt[i] = !vld_r[i] || (val_r[i] > ins_val);

    always_comb begin
      val_nxt[i] = val_r[i];
      vld_nxt[i] = vld_r[i];
      if (ins && gt[i]) begin
        if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
          val_nxt[i] = val_r[(i > 0) ? i - 1 : 0];
          vld_nxt[i] = vld_r[(i > 0) ? i - 1 : 0];
        end else begin
          val_nxt[i] = ins_val;
          vld_nxt[i] = 1'b1;
        end
      end else if (pop) begin
        if (i < DEPTH - 1) begin
          val_nxt[i] = val_r[(i < DEPTH - 1) ? i + 1 : i];
          vld_nxt[i] = vld_r[(i < DEPTH - 1) ? i + 1 : i];
        end else begin
          vld_nxt[i] = 1'b0;
        end
      end
    end

    always_ff @(posedge clk) begin
      val_r[i] <= val_nxt[i];
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (ins) begin
      count_nxt = count_r + CW'(1);
    end else if (pop) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      count_r <= '0;
    end else begin
      vld_r   <= vld_nxt;
      count_r <= count_nxt;
    end
  end

  assign head  = val_r[0];
  assign count = count_r;

endmodule

@@ hdl/pott_front.sv @@
// Accept and classify transactions; hold them in a two-entry command queue.
module pott_front
  import pott_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  output logic     full,
  input  in_item_t in_item,
  output logic     cmd_vld,
  output cmd_t     cmd,
  input  logic     cmd_pop
);

  cmd_t       q_r [2];
  cmd_t       new_cmd;
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       accept;
  logic       take;

  assign full    = (cnt_r == 2'd2);
  assign accept  = push && !full;
  assign cmd_vld = (cnt_r != 2'd0);
  assign take    = cmd_pop && cmd_vld;
  assign cmd     = q_r[rd_ptr_r];

  always_comb begin
    new_cmd.op     = in_item.op;
    new_cmd.target = in_item.target_id;
    // zero delay or period becomes one tick
    new_cmd.load   = (in_item.delay_ticks == '0) ? TICKS_W'(1) : in_item.delay_ticks;
    new_cmd.period = (in_item.op == OP_PERIODIC) ? new_cmd.load : '0;
  end

  always_comb begin
    wr_ptr_nxt = accept ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = take ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, accept} - {1'b0, take};
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_r[wr_ptr_r] <= new_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

@@ hdl/pott_back.sv @@
// Execute commands against the slot table; one slot per cycle through the RAM.
module pott_back
  import pott_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_vld,
  input  cmd_t      cmd,
  output logic      cmd_pop,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  state_t          state_r, state_nxt;
  cmd_t            cmd_r, cmd_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            proc_vld_r, proc_vld_nxt;
  logic [IW-1:0]   proc_idx_r, proc_idx_nxt;
  logic [SLOTS-1:0] live_r, live_nxt;
  logic [ID_W-1:0] next_ident_r, next_ident_nxt;
  logic            hit_r, hit_nxt;
  logic            out_vld_r, out_vld_nxt;
  out_item_t       out_item_r, out_item_nxt;

  logic            out_ready;
  logic            res_vld;
  out_item_t       res;
  logic            add_fire;

  logic            rd_en, wr_en;
  logic [IW-1:0]   rd_addr, wr_addr;
  logic [SLOT_W-1:0] rd_data, wr_data;
  slot_t           rd_slot, wr_slot;
  logic [TICKS_W-1:0] left_dec;

  logic            sort_ins, sort_pop;
  logic [ID_W-1:0] sort_head;
  logic [CW-1:0]   sort_cnt;

  pott_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  pott_sorter #(
    .DEPTH (SLOTS)
  ) u_sorter (
    .clk     (clk),
    .rst_n   (rst_n),
    .ins     (sort_ins),
    .ins_val (rd_slot.ident),
    .pop     (sort_pop),
    .head    (sort_head),
    .count   (sort_cnt)
  );

  assign rd_slot   = slot_t'(rd_data);
  assign wr_data   = SLOT_W'(wr_slot);
  assign left_dec  = rd_slot.left - TICKS_W'(1);
  assign out_ready = !out_vld_r || pop;
  assign rd_addr   = cnt_r[IW-1:0];

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    cnt_nxt        = cnt_r;
    proc_vld_nxt   = proc_vld_r;
    proc_idx_nxt   = proc_idx_r;
    live_nxt       = live_r;
    next_ident_nxt = next_ident_r;
    hit_nxt        = hit_r;
    cmd_pop        = 1'b0;
    rd_en          = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = proc_idx_r;
    wr_slot        = rd_slot;
    sort_ins       = 1'b0;
    sort_pop       = 1'b0;
    res_vld        = 1'b0;
    res.kind       = KIND_ADDED;
    res.task_id    = next_ident_r;
    res.last       = 1'b1;
    add_fire       = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (cmd_vld) begin
          cmd_pop      = 1'b1;
          cmd_nxt      = cmd;
          cnt_nxt      = '0;
          proc_vld_nxt = 1'b0;
          hit_nxt      = 1'b0;
          if (cmd.op == OP_TICK || cmd.op == OP_CANCEL) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_FIND;
          end
        end
      end

      ST_FIND: begin
        // walk the live bits for the lowest free slot
        if (cnt_r == CW'(SLOTS) || !live_r[cnt_r[IW-1:0]]) begin
          state_nxt = ST_ADD;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end

      ST_ADD: begin
        if (out_ready) begin
          res_vld   = 1'b1;
          state_nxt = ST_IDLE;
          if (cnt_r == CW'(SLOTS)) begin
            res.kind    = KIND_FULL;
            res.task_id = '0;
          end else begin
            add_fire                 = 1'b1;
            wr_en                    = 1'b1;
            wr_addr                  = cnt_r[IW-1:0];
            wr_slot.ident            = next_ident_r;
            wr_slot.left             = cmd_r.load;
            wr_slot.period           = cmd_r.period;
            live_nxt[cnt_r[IW-1:0]]  = 1'b1;
            next_ident_nxt           = next_ident_r + ID_W'(1);
          end
        end
      end

      ST_SCAN: begin
        // issue the read of the next slot
        if (cnt_r != CW'(SLOTS)) begin
          rd_en        = 1'b1;
          proc_vld_nxt = 1'b1;
          proc_idx_nxt = cnt_r[IW-1:0];
          cnt_nxt      = cnt_r + CW'(1);
        end else begin
          proc_vld_nxt = 1'b0;
          if (!proc_vld_r) begin
            state_nxt = (cmd_r.op == OP_TICK) ? ST_EMIT : ST_CANCEL_DONE;
          end
        end
        // handle the slot read in the previous cycle
        if (proc_vld_r && live_r[proc_idx_r]) begin
          if (cmd_r.op == OP_TICK) begin
            wr_en        = 1'b1;
            wr_slot.left = left_dec;
            if (left_dec == '0) begin
              sort_ins = 1'b1;
              if (rd_slot.period != '0) begin
                wr_slot.left = rd_slot.period;
              end else begin
                live_nxt[proc_idx_r] = 1'b0;
              end
            end
          end else if (rd_slot.ident == cmd_r.target) begin
            live_nxt[proc_idx_r] = 1'b0;
            hit_nxt              = 1'b1;
          end
        end
      end

      ST_EMIT: begin
        // drain fired ids in ascending order
        if (sort_cnt == '0) begin
          state_nxt = ST_IDLE;
        end else if (out_ready) begin
          sort_pop    = 1'b1;
          res_vld     = 1'b1;
          res.kind    = KIND_FIRED;
          res.task_id = sort_head;
          res.last    = (sort_cnt == CW'(1));
          if (sort_cnt == CW'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end

      ST_CANCEL_DONE: begin
        if (!hit_r) begin
          state_nxt = ST_IDLE;
        end else if (out_ready) begin
          res_vld     = 1'b1;
          res.kind    = KIND_CANCELLED;
          res.task_id = cmd_r.target;
          state_nxt   = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_vld_nxt  = out_vld_r;
    out_item_nxt = out_item_r;
    if (res_vld) begin
      out_vld_nxt  = 1'b1;
      out_item_nxt = res;
    end else if (pop) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    proc_idx_r <= proc_idx_nxt;
    out_item_r <= out_item_nxt;
    cnt_r      <= cnt_nxt;
    hit_r      <= hit_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      proc_vld_r   <= 1'b0;
      live_r       <= '0;
      next_ident_r <= ID_W'(1);
      out_vld_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      proc_vld_r   <= proc_vld_nxt;
      live_r       <= live_nxt;
      next_ident_r <= next_ident_nxt;
      out_vld_r    <= out_vld_nxt;
    end
  end

  assign empty    = !out_vld_r;
  assign out_item = out_item_r;

  // fired ids never linger into the next command
  a_sorter_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (sort_cnt == '0))
    else $error("fired ids left in sorter at idle");

  // ids are consumed only by a successful add
  a_ident_on_add: assert property (@(posedge clk) disable iff (!rst_n)
    !add_fire |=> $stable(next_ident_r))
    else $error("next id moved without an add");

  // a tick scan only frees slots
  a_tick_no_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && cmd_r.op == OP_TICK) |=>
      ($countones(live_r) <= $past($countones(live_r))))
    else $error("tick scan allocated a slot");

  // results only leave the back from a result-producing state
  a_result_state: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld |-> (state_r == ST_ADD || state_r == ST_EMIT || state_r == ST_CANCEL_DONE))
    else $error("result produced outside a result state");

endmodule

@@ hdl/periodic_oneshot_timer_table.sv @@
// Software timer table in ticks. Push a transaction (tick, add one-shot, add
// periodic, cancel) while full is low; read results while empty is low and
// pop them. An add takes the lowest free slot and returns the next id (ids
// start at 1 and wrap at 32 bits), or a table-full result with id 0. A tick
// counts down every live timer and returns one fired result per expiring
// timer, in ascending id order, the final one marked last; a tick with
// nothing due returns nothing. A cancel of a known id returns one result, of
// an unknown id nothing. The slot RAM is read one slot per cycle. An add
// runs through command pickup, the free-slot walk and its result; a tick
// through pickup, a scan of every slot and one result per fired timer; a
// cancel through pickup, a scan and, for a known id, its result. A result
// waiting to be popped stalls the back end when it has another to hand on.
// A two-entry command queue takes new transactions while the back end works
// and while a result waits to be popped. No clearing pass after reset.
module periodic_oneshot_timer_table
  import pott_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item
);

  // command queue between front and back
  logic cmd_vld;
  cmd_t cmd;
  logic cmd_pop;

  // front: accept and classify (zero delay/period raised to one tick)
  pott_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .cmd_vld (cmd_vld),
    .cmd     (cmd),
    .cmd_pop (cmd_pop)
  );

  // back: slot scans, id sorting and the result register
  pott_back #(
    .SLOTS (SLOTS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_vld  (cmd_vld),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

endmodule
